// ----- rtl/core/amgs_pkg.sv -----
// Shared types and constants of the adjacency matrix graph store.
package amgs_pkg;

  localparam int ACTION_W    = 3;
  localparam int VERTEX_W    = 6;
  localparam int WEIGHT_IN_W = 16;
  localparam int COUNT_OUT_W = 13;
  localparam int VCOUNT_W    = 7;

  localparam logic [ACTION_W-1:0] ACT_CLEAR  = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_INSERT = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_REMOVE = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_FIRST  = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_NEXT   = 3'd4;

  localparam logic [VCOUNT_W-1:0] VCOUNT_RESET = 7'd64;

  // Row select for reads and updates: row of vertex_a or row of vertex_b.
  localparam logic SEL_A = 1'b0;
  localparam logic SEL_B = 1'b1;

  typedef struct packed {
    logic load;
    logic clear_all;
    logic rd_row;
    logic rd_sel;
    logic upd_row;
    logic upd_sel;
    logic scan_enc;
    logic wt_rd;
  } amgs_cmd_t;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic                reject;
    logic                self_loop;
  } amgs_stat_t;

endpackage

// ----- rtl/core/amgs_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module amgs_ram
  #(parameter int WIDTH = 16,
    parameter int DEPTH = 64)
  (input  logic                     clk,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/core/amgs_ctrl.sv -----
// Controller state machine that sequences each graph transaction.
module amgs_ctrl
  import amgs_pkg::*;
  (input  logic       clk,
   input  logic       rst,
   input  logic       start,
   input  amgs_stat_t stat,
   output amgs_cmd_t  cmd,
   output logic       busy,
   output logic       done);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_DISPATCH = 3'd1;
  localparam logic [2:0] S_ROW_A    = 3'd2;
  localparam logic [2:0] S_ROW_B    = 3'd3;
  localparam logic [2:0] S_SCAN_ROW = 3'd4;
  localparam logic [2:0] S_SCAN_WT  = 3'd5;
  localparam logic [2:0] S_DONE     = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.rd_sel  = SEL_A;
    cmd.upd_sel = SEL_A;
    case (state)
      S_IDLE, S_DONE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_DISPATCH;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_DISPATCH: begin
        if (stat.reject) begin
          state_next = S_DONE;
        end else begin
          case (stat.action)
            ACT_CLEAR: begin
              cmd.clear_all = 1'b1;
              state_next    = S_DONE;
            end
            ACT_INSERT, ACT_REMOVE: begin
              cmd.rd_row = 1'b1;
              state_next = S_ROW_A;
            end
            ACT_FIRST, ACT_NEXT: begin
              cmd.rd_row = 1'b1;
              state_next = S_SCAN_ROW;
            end
            default: begin
              state_next = S_DONE;
            end
          endcase
        end
      end
      S_ROW_A: begin
        cmd.upd_row = 1'b1;
        // A self loop is a single entry, so the second row is skipped.
        if (stat.self_loop) begin
          state_next = S_DONE;
        end else begin
          cmd.rd_row = 1'b1;
          cmd.rd_sel = SEL_B;
          state_next = S_ROW_B;
        end
      end
      S_ROW_B: begin
        cmd.upd_row = 1'b1;
        cmd.upd_sel = SEL_B;
        state_next  = S_DONE;
      end
      S_SCAN_ROW: begin
        cmd.scan_enc = 1'b1;
        state_next   = S_SCAN_WT;
      end
      S_SCAN_WT: begin
        cmd.wt_rd  = 1'b1;
        state_next = S_DONE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign busy = (state != S_IDLE) && (state != S_DONE);
  assign done = (state == S_DONE);

endmodule

// ----- rtl/core/amgs_dpath.sv -----
// Datapath: request registers, presence rows, weights, scan encoder and entry count.
module amgs_dpath
  import amgs_pkg::*;
  #(parameter int MAX_VERTICES = 64,
    parameter int WEIGHT_BITS  = 16)
  (input  logic                   clk,
   input  logic                   rst,
   input  amgs_cmd_t              cmd,
   output amgs_stat_t             stat,
   input  logic                   cfg_write,
   input  logic [VCOUNT_W-1:0]    cfg_data,
   input  logic [ACTION_W-1:0]    action,
   input  logic [VERTEX_W-1:0]    vertex_a,
   input  logic [VERTEX_W-1:0]    vertex_b,
   input  logic [WEIGHT_IN_W-1:0] weight,
   output logic                   status,
   output logic                   found,
   output logic [VERTEX_W-1:0]    neighbour,
   output logic [WEIGHT_IN_W-1:0] neighbour_weight,
   output logic [COUNT_OUT_W-1:0] entry_count);

  localparam int VW = $clog2(MAX_VERTICES);
  localparam int SW = VW + 1;
  localparam int LW = $clog2(MAX_VERTICES + 1);
  localparam int AW = $clog2(MAX_VERTICES * MAX_VERTICES);
  localparam int CW = $clog2(MAX_VERTICES * MAX_VERTICES + 1);

  logic [VCOUNT_W-1:0]     vcount;
  logic [LW-1:0]           live;
  logic                    a_ok;
  logic                    b_ok;
  logic                    reject_in;

  logic [ACTION_W-1:0]     req_action;
  logic [VW-1:0]           req_a;
  logic [VW-1:0]           req_b;
  logic [WEIGHT_BITS-1:0]  req_w;
  logic [SW-1:0]           start_col;
  logic                    reject;

  logic [MAX_VERTICES-1:0] row_valid;
  logic                    rd_valid;
  logic [MAX_VERTICES-1:0] row_rdata;
  logic [MAX_VERTICES-1:0] row_eff;
  logic [MAX_VERTICES-1:0] row_new;
  logic [VW-1:0]           upd_idx;
  logic [VW-1:0]           upd_col;
  logic                    old_bit;
  logic                    is_insert;
  logic [VW-1:0]           rd_idx;

  logic [MAX_VERTICES-1:0] masked;
  logic [VW-1:0]           enc;
  logic                    found_q;
  logic [VW-1:0]           nb_q;

  logic [AW-1:0]           wt_waddr;
  logic [AW-1:0]           wt_raddr;
  logic [WEIGHT_BITS-1:0]  wt_rdata;
  logic [31:0]             wt_ext;
  logic [31:0]             w_in_ext;
  logic [CW-1:0]           cnt;

  // Register values above the matrix size act as the full size.
  assign live = (32'(vcount) > 32'(MAX_VERTICES)) ? LW'(MAX_VERTICES) : LW'(vcount);
  assign a_ok = 32'(vertex_a) < 32'(live);
  assign b_ok = 32'(vertex_b) < 32'(live);

  always_comb begin
    case (action)
      ACT_INSERT, ACT_REMOVE, ACT_NEXT: reject_in = !a_ok || !b_ok;
      ACT_FIRST:                        reject_in = !a_ok;
      default:                          reject_in = 1'b0;
    endcase
  end

  assign w_in_ext = 32'(weight);

  always_ff @(posedge clk) begin
    if (rst) begin
      vcount <= VCOUNT_RESET;
    end else if (cfg_write) begin
      vcount <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_action <= action;
      req_a      <= VW'(vertex_a);
      req_b      <= VW'(vertex_b);
      req_w      <= w_in_ext[WEIGHT_BITS-1:0];
      start_col  <= (action == ACT_NEXT) ? SW'(vertex_b) + SW'(1) : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      reject <= 1'b0;
    end else if (cmd.load) begin
      reject <= reject_in;
    end
  end

  assign stat.action    = req_action;
  assign stat.reject    = reject;
  assign stat.self_loop = (req_a == req_b);

  // Presence rows: a row that is not valid reads as all absent.
  assign rd_idx    = (cmd.rd_sel == SEL_B) ? req_b : req_a;
  assign upd_idx   = (cmd.upd_sel == SEL_B) ? req_b : req_a;
  assign upd_col   = (cmd.upd_sel == SEL_B) ? req_a : req_b;
  assign row_eff   = rd_valid ? row_rdata : '0;
  assign old_bit   = row_eff[upd_col];
  assign is_insert = (req_action == ACT_INSERT);

  always_comb begin
    row_new          = row_eff;
    row_new[upd_col] = is_insert;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
      rd_valid  <= 1'b0;
    end else begin
      if (cmd.clear_all) begin
        row_valid <= '0;
      end else if (cmd.upd_row) begin
        row_valid[upd_idx] <= 1'b1;
      end
      if (cmd.rd_row) begin
        rd_valid <= row_valid[rd_idx];
      end
    end
  end

  amgs_ram #(.WIDTH(MAX_VERTICES), .DEPTH(MAX_VERTICES)) u_row_ram (
    .clk   (clk),
    .we    (cmd.upd_row),
    .waddr (upd_idx),
    .wdata (row_new),
    .re    (cmd.rd_row),
    .raddr (rd_idx),
    .rdata (row_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (cmd.clear_all) begin
      cnt <= '0;
    end else if (cmd.upd_row) begin
      if (is_insert && !old_bit) begin
        cnt <= cnt + CW'(1);
      end else if (!is_insert && old_bit) begin
        cnt <= cnt - CW'(1);
      end
    end
  end

  // Lowest present column at or above the start column and below the live count.
  always_comb begin
    enc = '0;
    for (int c = 0; c < MAX_VERTICES; c++) begin
      masked[c] = row_eff[c] && (SW'(c) >= start_col) && (LW'(c) < live);
    end
    for (int c = MAX_VERTICES - 1; c >= 0; c--) begin
      if (masked[c]) begin
        enc = VW'(c);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      found_q <= 1'b0;
      nb_q    <= '0;
    end else if (cmd.load) begin
      found_q <= 1'b0;
      nb_q    <= '0;
    end else if (cmd.scan_enc) begin
      found_q <= |masked;
      nb_q    <= enc;
    end
  end

  assign wt_waddr = AW'(upd_idx) * AW'(MAX_VERTICES) + AW'(upd_col);
  assign wt_raddr = AW'(req_a) * AW'(MAX_VERTICES) + AW'(nb_q);

  amgs_ram #(.WIDTH(WEIGHT_BITS), .DEPTH(MAX_VERTICES * MAX_VERTICES)) u_wt_ram (
    .clk   (clk),
    .we    (cmd.upd_row && is_insert),
    .waddr (wt_waddr),
    .wdata (req_w),
    .re    (cmd.wt_rd),
    .raddr (wt_raddr),
    .rdata (wt_rdata)
  );

  assign wt_ext           = 32'(wt_rdata);
  assign status           = reject;
  assign found            = found_q;
  assign neighbour        = VERTEX_W'(nb_q);
  assign neighbour_weight = found_q ? wt_ext[WEIGHT_IN_W-1:0] : '0;
  assign entry_count      = COUNT_OUT_W'(cnt);

endmodule

// ----- rtl/core/adjacency_matrix_graph_store_top.sv -----
// Sequence: an accepted transaction goes from DISPATCH to DONE for clear, rejected and unknown actions,
// through ROW_A for a self-loop insert or remove, through ROW_A and ROW_B for other inserts and removes,
// and through SCAN_ROW and SCAN_WT for scans. A new transaction is taken in the done cycle; none is
// taken while the read-modify-write of presence rows or the row read, encode, weight read of a scan runs.
// Reset clears the presence row valid bits, entry count and control, and sets vertex_count to 64.
// The receiver cannot stall; each result is shown for exactly one cycle with done.
module adjacency_matrix_graph_store_top
  import amgs_pkg::*;
  #(parameter int MAX_VERTICES = 64,
    parameter int WEIGHT_BITS  = 16)
  (input  logic                   clk,
   input  logic                   rst,
   input  logic                   start,
   output logic                   busy,
   input  logic [ACTION_W-1:0]    action,
   input  logic [VERTEX_W-1:0]    vertex_a,
   input  logic [VERTEX_W-1:0]    vertex_b,
   input  logic [WEIGHT_IN_W-1:0] weight,
   output logic                   done,
   output logic                   status,
   output logic                   found,
   output logic [VERTEX_W-1:0]    neighbour,
   output logic [WEIGHT_IN_W-1:0] neighbour_weight,
   output logic [COUNT_OUT_W-1:0] entry_count,
   input  logic                   cfg_write,
   input  logic [VCOUNT_W-1:0]    cfg_data);

  amgs_cmd_t  cmd;
  amgs_stat_t stat;

  amgs_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  amgs_dpath #(.MAX_VERTICES(MAX_VERTICES), .WEIGHT_BITS(WEIGHT_BITS)) u_dpath (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .stat             (stat),
    .cfg_write        (cfg_write),
    .cfg_data         (cfg_data),
    .action           (action),
    .vertex_a         (vertex_a),
    .vertex_b         (vertex_b),
    .weight           (weight),
    .status           (status),
    .found            (found),
    .neighbour        (neighbour),
    .neighbour_weight (neighbour_weight),
    .entry_count      (entry_count)
  );

  // An accepted transaction always occupies the controller in the next cycle.
  assert property (@(posedge clk) disable iff (rst) (start && !busy) |=> busy)
    else $error("accepted transaction did not start work");

  // A result only follows a cycle of work.
  assert property (@(posedge clk) disable iff (rst) done |-> $past(busy))
    else $error("result strobe without preceding work");

  // A rejected transaction never reports a neighbour.
  assert property (@(posedge clk) disable iff (rst) (done && status) |-> !found)
    else $error("rejected transaction reported a neighbour");

  // Without a neighbour the column and weight read as zero.
  assert property (@(posedge clk) disable iff (rst)
                   (done && !found) |-> (neighbour == '0 && neighbour_weight == '0))
    else $error("neighbour fields not zero when nothing was found");

endmodule
